### hdl/mudc_pkg.sv
// Shared constants, codes and bundle types for the mesh uplink discovery controller.
`timescale 1ns / 1ps
package mudc_pkg;

  localparam int ADDRESS_WIDTH_DEFAULT = 8;
  localparam int STRENGTH_W = 8;
  localparam int KIND_W     = 3;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 3;
  localparam int RETRY_W    = 4;
  localparam int CFG_IDX_W  = 3;

  // request types
  localparam logic [REQ_W-1:0] REQ_PACKET  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_OUTCOME = 3'd1;
  localparam logic [REQ_W-1:0] REQ_OWN     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOOK    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_WEND    = 3'd4;

  // packet kinds
  localparam logic [KIND_W-1:0] K_DATA = 3'd0;
  localparam logic [KIND_W-1:0] K_ASK  = 3'd1;
  localparam logic [KIND_W-1:0] K_AMC  = 3'd2;
  localparam logic [KIND_W-1:0] K_HAVE = 3'd3;
  localparam logic [KIND_W-1:0] K_DROP = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] ST_SUCCESS = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAIL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_AWAIT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_COORD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_EN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST     = 3'd5;

  // reset values of the registers
  localparam logic [STRENGTH_W-1:0] MIN_STR_RESET   = 8'd128;
  localparam logic [RETRY_W-1:0]    RETRY_LIM_RESET = 4'd3;

  typedef struct packed {
    logic                  is_coordinator;
    logic [STRENGTH_W-1:0] min_strength;
    logic [RETRY_W-1:0]    retry_limit;
    logic                  ack_enable;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [KIND_W-1:0]     packet_kind;
    logic [STRENGTH_W-1:0] signal_strength;
    logic                  acknowledged;
  } item_t;

  typedef struct packed {
    logic                  send_valid;
    logic [KIND_W-1:0]     send_kind;
    logic                  send_held_packet;
    logic [STATUS_W-1:0]   status;
    logic                  uplink_up;
    logic [STRENGTH_W-1:0] hop_strength;
  } res_t;

endpackage

### hdl/mudc_cfg_regs.sv
// Configuration register file with plain write port.
`timescale 1ns / 1ps
module mudc_cfg_regs import mudc_pkg::*; #(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEFAULT,
  localparam int CFG_W = (ADDRESS_WIDTH > STRENGTH_W) ? ADDRESS_WIDTH : STRENGTH_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output cfg_t                     cfg,
  output logic [ADDRESS_WIDTH-1:0] bcast
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.is_coordinator <= 1'b0;
      cfg.min_strength   <= MIN_STR_RESET;
      cfg.retry_limit    <= RETRY_LIM_RESET;
      cfg.ack_enable     <= 1'b1;
      bcast              <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_ID: begin
          // own address only matters for packet assembly, outside this block
        end
        CFG_IS_COORD:  cfg.is_coordinator <= cfg_data[0];
        CFG_MIN_STR:   cfg.min_strength   <= cfg_data[STRENGTH_W-1:0];
        CFG_RETRY_LIM: cfg.retry_limit    <= cfg_data[RETRY_W-1:0];
        CFG_ACK_EN:    cfg.ack_enable     <= cfg_data[0];
        CFG_BCAST:     bcast              <= cfg_data[ADDRESS_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/mudc_in_reg.sv
// Input request register.
`timescale 1ns / 1ps
module mudc_in_reg import mudc_pkg::*; #(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  item_t                    in_item,
  input  logic [ADDRESS_WIDTH-1:0] in_src,
  input  logic                     advance,
  output logic                     held_valid,
  output item_t                    held_item,
  output logic [ADDRESS_WIDTH-1:0] held_src
);

  logic load;

  assign in_stall = held_valid & ~advance;
  assign load     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
      held_src  <= in_src;
    end
  end

endmodule

### hdl/mudc_node_core.sv
// Node state and per-request decision logic.
`timescale 1ns / 1ps
module mudc_node_core import mudc_pkg::*; #(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  item_t                    item,
  input  logic [ADDRESS_WIDTH-1:0] src,
  input  cfg_t                     cfg,
  input  logic [ADDRESS_WIDTH-1:0] bcast,
  output res_t                     res,
  output logic [ADDRESS_WIDTH-1:0] res_dest,
  output logic [ADDRESS_WIDTH-1:0] res_hop
);

  logic                     uplink_flag, uplink_flag_next;
  logic                     candidate_found, candidate_found_next;
  logic [ADDRESS_WIDTH-1:0] next_hop, next_hop_next;
  logic [STRENGTH_W-1:0]    best_strength, best_strength_next;
  logic                     send_pending, send_pending_next;
  logic [KIND_W-1:0]        pending_kind, pending_kind_next;
  logic [ADDRESS_WIDTH-1:0] pending_destination, pending_destination_next;
  logic                     pending_held, pending_held_next;
  logic                     drop_on_failure, drop_on_failure_next;
  logic [RETRY_W-1:0]       fail_count, fail_count_next;

  logic                     do_send, do_drop;
  logic [KIND_W-1:0]        s_kind;
  logic [ADDRESS_WIDTH-1:0] s_dest;
  logic                     s_held, s_dof;

  always_comb begin
    uplink_flag_next         = uplink_flag;
    candidate_found_next     = candidate_found;
    next_hop_next            = next_hop;
    best_strength_next       = best_strength;
    send_pending_next        = send_pending;
    pending_kind_next        = pending_kind;
    pending_destination_next = pending_destination;
    pending_held_next        = pending_held;
    drop_on_failure_next     = drop_on_failure;
    fail_count_next          = fail_count;

    do_send = 1'b0;
    do_drop = 1'b0;
    s_kind  = K_DATA;
    s_dest  = '0;
    s_held  = 1'b0;
    s_dof   = 1'b0;

    res.send_valid       = 1'b0;
    res.send_kind        = K_DATA;
    res.send_held_packet = 1'b0;
    res.status           = ST_IGNORED;
    res_dest             = '0;

    if (send_pending && item.req_type != REQ_OUTCOME) begin
      res.status = ST_BUSY;
    end else begin
      case (item.req_type)
        REQ_PACKET: begin
          if (cfg.is_coordinator) begin
            if (item.packet_kind == K_DATA) begin
              res.status = ST_SUCCESS;
            end else if (item.packet_kind == K_ASK) begin
              do_send = 1'b1; s_kind = K_AMC; s_dest = src;
            end
          end else if (uplink_flag) begin
            if (item.packet_kind == K_DATA) begin
              do_send = 1'b1; s_kind = K_DATA; s_dest = next_hop;
              s_held = 1'b1;  s_dof = 1'b1;
            end else if (item.packet_kind == K_DROP) begin
              do_drop = (src == next_hop);
            end else if (item.packet_kind == K_ASK) begin
              do_send = 1'b1; s_kind = K_HAVE; s_dest = src;
            end
          end else begin
            if (item.packet_kind == K_AMC || item.packet_kind == K_HAVE) begin
              if (item.signal_strength > cfg.min_strength &&
                  item.signal_strength > best_strength) begin
                candidate_found_next = 1'b1;
                best_strength_next   = item.signal_strength;
                next_hop_next        = src;
                res.status           = ST_SUCCESS;
              end
            end else if (item.packet_kind == K_DATA) begin
              // no uplink yet: tell the sender its data went nowhere
              do_send = 1'b1; s_kind = K_DROP; s_dest = src;
            end
          end
        end
        REQ_OUTCOME: begin
          if (send_pending) begin
            if (item.acknowledged) begin
              send_pending_next = 1'b0;
              res.status        = ST_SUCCESS;
            end else if (fail_count < cfg.retry_limit) begin
              fail_count_next      = fail_count + RETRY_W'(1);
              res.send_valid       = 1'b1;
              res.send_kind        = pending_kind;
              res_dest             = pending_destination;
              res.send_held_packet = pending_held;
              res.status           = ST_AWAIT;
            end else begin
              send_pending_next = 1'b0;
              if (drop_on_failure) begin
                do_drop = 1'b1;
              end else begin
                res.status = ST_FAIL;
              end
            end
          end
        end
        REQ_OWN: begin
          if (!cfg.is_coordinator && uplink_flag) begin
            do_send = 1'b1; s_kind = K_DATA; s_dest = next_hop; s_dof = 1'b1;
          end
        end
        REQ_LOOK: begin
          if (!cfg.is_coordinator && !uplink_flag) begin
            do_send = 1'b1; s_kind = K_ASK; s_dest = bcast;
          end
        end
        REQ_WEND: begin
          if (!cfg.is_coordinator && !uplink_flag && candidate_found) begin
            candidate_found_next = 1'b0;
            uplink_flag_next     = 1'b1;
            do_send = 1'b1; s_kind = K_HAVE; s_dest = bcast;
          end
        end
        default: begin
        end
      endcase
    end

    if (do_send) begin
      res.send_valid       = 1'b1;
      res.send_kind        = s_kind;
      res_dest             = s_dest;
      res.send_held_packet = s_held;
      if (cfg.ack_enable && s_dest != bcast) begin
        send_pending_next        = 1'b1;
        pending_kind_next        = s_kind;
        pending_destination_next = s_dest;
        pending_held_next        = s_held;
        drop_on_failure_next     = s_dof;
        fail_count_next          = '0;
        res.status               = ST_AWAIT;
      end else begin
        res.status = ST_SUCCESS;
      end
    end

    if (do_drop) begin
      uplink_flag_next     = 1'b0;
      best_strength_next   = '0;
      res.send_valid       = 1'b1;
      res.send_kind        = K_DROP;
      res_dest             = bcast;
      res.send_held_packet = 1'b0;
      res.status           = ST_DROPPED;
    end

    res.uplink_up    = uplink_flag_next;
    res.hop_strength = best_strength_next;
    res_hop          = next_hop_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uplink_flag         <= 1'b0;
      candidate_found     <= 1'b0;
      next_hop            <= '0;
      best_strength       <= '0;
      send_pending        <= 1'b0;
      pending_kind        <= K_DATA;
      pending_destination <= '0;
      pending_held        <= 1'b0;
      drop_on_failure     <= 1'b0;
      fail_count          <= '0;
    end else if (fire) begin
      uplink_flag         <= uplink_flag_next;
      candidate_found     <= candidate_found_next;
      next_hop            <= next_hop_next;
      best_strength       <= best_strength_next;
      send_pending        <= send_pending_next;
      pending_kind        <= pending_kind_next;
      pending_destination <= pending_destination_next;
      pending_held        <= pending_held_next;
      drop_on_failure     <= drop_on_failure_next;
      fail_count          <= fail_count_next;
    end
  end

endmodule

### hdl/mudc_out_reg.sv
// Result register on the output channel.
`timescale 1ns / 1ps
module mudc_out_reg import mudc_pkg::*; #(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     held_valid,
  output logic                     advance,
  input  res_t                     res,
  input  logic [ADDRESS_WIDTH-1:0] res_dest,
  input  logic [ADDRESS_WIDTH-1:0] res_hop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output res_t                     out_res,
  output logic [ADDRESS_WIDTH-1:0] out_dest,
  output logic [ADDRESS_WIDTH-1:0] out_hop
);

  logic load;

  assign advance = ~out_valid | ~out_stall;
  assign load    = held_valid & advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= res;
      out_dest <= res_dest;
      out_hop  <= res_hop;
    end
  end

endmodule

### hdl/mesh_uplink_discovery_controller.sv
// Mesh uplink discovery controller: top level.
// A request waits in the input register; the node core decides it and the result register drives out_valid.
// Throughput: one request per cycle while the result channel is not stalled; the node state feedback is combinational.
// A stalled result holds the input register, which then stalls the input channel.
// Reset (rst, synchronous): registers to defaults, node state cleared, both stages empty.
`timescale 1ns / 1ps
module mesh_uplink_discovery_controller import mudc_pkg::*; #(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEFAULT,
  localparam int CFG_W = (ADDRESS_WIDTH > STRENGTH_W) ? ADDRESS_WIDTH : STRENGTH_W
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [KIND_W-1:0]        packet_kind,
  input  logic [ADDRESS_WIDTH-1:0] source_address,
  input  logic [STRENGTH_W-1:0]    signal_strength,
  input  logic                     acknowledged,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     send_valid,
  output logic [KIND_W-1:0]        send_kind,
  output logic [ADDRESS_WIDTH-1:0] send_destination,
  output logic                     send_held_packet,
  output logic [STATUS_W-1:0]      status,
  output logic                     uplink_up,
  output logic [ADDRESS_WIDTH-1:0] hop_address,
  output logic [STRENGTH_W-1:0]    hop_strength
);

  cfg_t                     cfg;
  logic [ADDRESS_WIDTH-1:0] bcast;

  item_t                    in_item;
  item_t                    held_item;
  logic [ADDRESS_WIDTH-1:0] held_src;
  logic                     held_valid;
  logic                     advance;
  logic                     fire;

  res_t                     res;
  res_t                     out_res;
  logic [ADDRESS_WIDTH-1:0] res_dest, res_hop;

  assign in_item.req_type        = req_type;
  assign in_item.packet_kind     = packet_kind;
  assign in_item.signal_strength = signal_strength;
  assign in_item.acknowledged    = acknowledged;

  // node state moves only when the held request drops into the result register
  assign fire = held_valid & advance;

  mudc_cfg_regs #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .bcast     (bcast)
  );

  mudc_in_reg #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .in_src     (source_address),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item),
    .held_src   (held_src)
  );

  mudc_node_core #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (held_item),
    .src      (held_src),
    .cfg      (cfg),
    .bcast    (bcast),
    .res      (res),
    .res_dest (res_dest),
    .res_hop  (res_hop)
  );

  mudc_out_reg #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_out (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .advance    (advance),
    .res        (res),
    .res_dest   (res_dest),
    .res_hop    (res_hop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .out_dest   (send_destination),
    .out_hop    (hop_address)
  );

  assign send_valid       = out_res.send_valid;
  assign send_kind        = out_res.send_kind;
  assign send_held_packet = out_res.send_held_packet;
  assign status           = out_res.status;
  assign uplink_up        = out_res.uplink_up;
  assign hop_strength     = out_res.hop_strength;

endmodule

### hdl/mudc_checker.sv
// Port-level assertions for the controller, bound to the top level.
`timescale 1ns / 1ps
module mudc_checker import mudc_pkg::*; #(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEFAULT
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     send_valid,
  input logic [KIND_W-1:0]        send_kind,
  input logic [ADDRESS_WIDTH-1:0] send_destination,
  input logic                     send_held_packet,
  input logic [STATUS_W-1:0]      status,
  input logic                     uplink_up,
  input logic [STRENGTH_W-1:0]    hop_strength
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(send_kind)
      && $stable(send_destination))
    else $error("stalled result changed");

  a_no_send_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !send_valid |-> send_kind == K_DATA && send_destination == '0
      && !send_held_packet)
    else $error("send fields nonzero without a send");

  a_await_sends: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_AWAIT |-> send_valid)
    else $error("awaiting ack without a transmit");

  a_drop_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DROPPED |-> send_valid && send_kind == K_DROP
      && !uplink_up && hop_strength == '0)
    else $error("drop result inconsistent");

  a_busy_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BUSY |-> !send_valid)
    else $error("busy result carries a transmit");

endmodule

bind mesh_uplink_discovery_controller mudc_checker #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_mudc_chk (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .send_valid       (send_valid),
  .send_kind        (send_kind),
  .send_destination (send_destination),
  .send_held_packet (send_held_packet),
  .status           (status),
  .uplink_up        (uplink_up),
  .hop_strength     (hop_strength)
);
